[hw/rtl/stg_pkg.sv]
// Package for the sine tone generator: request and response structs, widths,
// op codes and the elaboration-time sine table functions.
// No dependencies.
`default_nettype none

package stg_pkg;

	localparam int unsigned PHASE_W = 32;
	localparam int unsigned STEP_W  = 31;
	localparam int unsigned DUR_W   = 12;
	localparam int unsigned VOL_W   = 16;
	localparam int unsigned SMP_W   = 16;
	localparam int unsigned IDX_W   = 16;

	localparam int unsigned DIV_STEPS  = 4;
	localparam int unsigned DIV_CYCLES = SMP_W / DIV_STEPS;

	localparam int unsigned DEF_SINE_INDEX_BITS = 10;
	localparam int unsigned DEF_RAMP_MAX        = 80;
	localparam int unsigned DEF_SAMPLES_PER_MS  = 16;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SINE_AMP    = 64'd32767;
	localparam logic [63:0] TAYLOR_DIV [1:10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef struct packed {
		logic               op;
		logic [STEP_W-1:0]  phase_step;
		logic [DUR_W-1:0]   length_ms;
		logic [VOL_W-1:0]   volume;
	} tone_req_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
	} pcm_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// round(32767 * sin(pi/2 * k / quarter)), Q2.30 Taylor series
	function automatic logic [15:0] quarter_sine(input int unsigned idx_bits,
			input logic [63:0] k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		x    = (HALF_PI_Q30 * k) >> (idx_bits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = (sum * SINE_AMP + (64'd1 << 29)) >> 30;
		if (r > SINE_AMP) begin
			r = SINE_AMP;
		end
		return r[15:0];
	endfunction

	function automatic logic [15:0] sine_entry(input int unsigned idx_bits,
			input logic [63:0] i);
		logic [63:0] quarter;
		logic [63:0] q;
		logic [63:0] r;
		logic [15:0] m;
		quarter = 64'd1 << (idx_bits - 2);
		q       = (i >> (idx_bits - 2)) & 64'd3;
		r       = i & (quarter - 64'd1);
		m       = q[0] ? quarter_sine(idx_bits, quarter - r) : quarter_sine(idx_bits, r);
		return q[1] ? 16'(-m) : m;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/stg_sine_rom.sv]
// Synchronous sine ROM, registered read.
// Contents built at elaboration by stg_pkg::sine_entry.
`default_nettype none

module stg_sine_rom
	import stg_pkg::*;
#(
	parameter int unsigned SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [SINE_INDEX_BITS-1:0] addr,
	output logic [SMP_W-1:0]           data
);

	localparam int unsigned ROM_SIZE = 1 << SINE_INDEX_BITS;

	logic [SMP_W-1:0] rom_mem [ROM_SIZE];
	logic [SMP_W-1:0] data_q;

	for (genvar i = 0; i < ROM_SIZE; i++) begin : g_rom
		assign rom_mem[i] = sine_entry(SINE_INDEX_BITS, 64'(i));
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom_mem[addr];
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

[hw/rtl/stg_env_div.sv]
// Envelope divider: restoring division, DIV_STEPS quotient bits per cycle.
// Depends on stg_pkg for widths and the status struct.
`default_nettype none

module stg_env_div
	import stg_pkg::*;
#(
	parameter int unsigned RLW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [SMP_W+RLW-1:0] dividend,
	input  logic [RLW-1:0]       divisor,
	output logic [SMP_W-1:0]     quotient,
	output div_stat_t            stat
);

	localparam int unsigned CNT_W = $clog2(DIV_CYCLES + 1);

	logic [RLW:0]       rem_q;
	logic [RLW:0]       rem_n;
	logic [SMP_W-1:0]   quo_q;
	logic [SMP_W-1:0]   quo_n;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	// upper dividend bits are below the divisor, so the quotient fits SMP_W
	always_comb begin
		logic [RLW:0] shifted;
		rem_n = rem_q;
		quo_n = quo_q;
		for (int s = 0; s < DIV_STEPS; s++) begin
			shifted = {rem_n[RLW-1:0], quo_n[SMP_W-1]};
			quo_n   = {quo_n[SMP_W-2:0], 1'b0};
			if (shifted >= {1'b0, divisor}) begin
				rem_n    = shifted - {1'b0, divisor};
				quo_n[0] = 1'b1;
			end else begin
				rem_n = shifted;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_CYCLES);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[SMP_W +: RLW]};
			quo_q <= dividend[SMP_W-1:0];
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

[hw/rtl/sine_tone_generator_with_ramp.sv]
// Top level of the DDS sine tone generator with linear attack/decay ramp.
// Uses stg_pkg, stg_sine_rom and stg_env_div.
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+-------------------------------
//   request  | tone_valid  | tone_stall  | tone (op, step, duration, vol)
//   sample   | pcm_valid   | pcm_stall   | pcm  (sample, last)
//
// Start requests and ticks while no tone is active leave the state idle.
// A tick inside a ramp passes through accept, ROM read, volume and envelope
// multiply, the 4-bit-per-cycle divider and its done flag, and output load.
// A tick outside the ramps skips the divider.
// The output register holds one sample; a stalled sample blocks the next load.
// Reset clears the tone state to idle; no clearing pass is needed.
`default_nettype none

module sine_tone_generator_with_ramp
	import stg_pkg::*;
#(
	parameter int unsigned SINE_INDEX_BITS = DEF_SINE_INDEX_BITS,
	parameter int unsigned RAMP_MAX        = DEF_RAMP_MAX,
	parameter int unsigned SAMPLES_PER_MS  = DEF_SAMPLES_PER_MS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tone_valid,
	output logic      tone_stall,
	input  tone_req_t tone,
	output logic      pcm_valid,
	input  logic      pcm_stall,
	output pcm_rsp_t  pcm
);

	localparam int unsigned RLW    = $clog2(RAMP_MAX + 1);
	localparam int unsigned SPM_W  = $clog2(SAMPLES_PER_MS + 1);
	localparam int unsigned NP_RAW = DUR_W + SPM_W;
	localparam int unsigned NP_W   = (NP_RAW > 17) ? NP_RAW : 17;
	localparam int unsigned DIVD_W = SMP_W + RLW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROM  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]          state_q;
	logic                active_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [STEP_W-1:0]   step_q;
	logic [VOL_W-1:0]    vol_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    total_q;
	logic [RLW-1:0]      rl_q;

	logic                env_s1;
	logic [RLW-1:0]      factor_s1;
	logic                last_s1;
	logic [31:0]         prod_s2;
	logic                neg_s2;
	logic [SMP_W-1:0]    mag_q;
	logic                neg_q;
	pcm_rsp_t            pcm_q;
	logic                pcm_valid_q;

	logic                accept;
	logic                start_ok;
	logic                tick_go;
	logic [NP_W-1:0]     nprod;
	logic [IDX_W-1:0]    n_sat;
	logic [IDX_W-3:0]    quarter;
	logic [RLW-1:0]      rl_new;
	logic [IDX_W-1:0]    rl_ext;
	logic [IDX_W-1:0]    left;
	logic                env_lo;
	logic                env_hi;
	logic [RLW-1:0]      factor;
	logic                env;
	logic                is_last;
	logic [SMP_W-1:0]    raw;
	logic                raw_neg;
	logic [SMP_W-1:0]    raw_mag;
	logic [31:0]         prod_adj;
	logic [SMP_W-1:0]    vmag;
	logic                div_start;
	logic [DIVD_W-1:0]   dividend;
	logic [SMP_W-1:0]    div_quo;
	div_stat_t           div_st;
	logic                pcm_load;

	assign tone_stall = (state_q != ST_IDLE);
	assign accept     = tone_valid && !tone_stall;
	assign start_ok   = accept && (tone.op == OP_START) &&
		(tone.phase_step != '0) && (tone.length_ms != '0);
	assign tick_go    = accept && (tone.op == OP_TICK) && active_q;

	assign nprod   = NP_W'(SAMPLES_PER_MS) * NP_W'(tone.length_ms);
	assign n_sat   = (nprod > NP_W'(17'h0FFFF)) ? '1 : nprod[IDX_W-1:0];
	assign quarter = n_sat[IDX_W-1:2];
	assign rl_new  = (quarter > (IDX_W-2)'(RAMP_MAX)) ? RLW'(RAMP_MAX) : quarter[RLW-1:0];

	assign rl_ext  = IDX_W'(rl_q);
	assign left    = total_q - idx_q;
	assign env_lo  = idx_q < rl_ext;
	assign env_hi  = idx_q > (total_q - rl_ext);
	assign factor  = env_lo ? idx_q[RLW-1:0] : left[RLW-1:0];
	assign env     = (rl_q != '0) && (env_lo || env_hi);
	assign is_last = ({1'b0, idx_q} + 17'd1) >= {1'b0, total_q};

	stg_sine_rom #(
		.SINE_INDEX_BITS(SINE_INDEX_BITS)
	) u_rom (
		.clk   (clk),
		.rd_en (tick_go),
		.addr  (phase_q[PHASE_W-1 -: SINE_INDEX_BITS]),
		.data  (raw)
	);

	assign raw_neg = raw[SMP_W-1];
	assign raw_mag = raw_neg ? SMP_W'(-raw) : raw;

	// floor of the signed product over 2^16
	assign prod_adj = neg_s2 ? (prod_s2 + 32'h0000FFFF) : prod_s2;
	assign vmag     = prod_adj[31:16];

	assign div_start = (state_q == ST_MUL) && env_s1;
	assign dividend  = DIVD_W'(vmag) * DIVD_W'(factor_s1);

	stg_env_div #(
		.RLW(RLW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (rl_q),
		.quotient (div_quo),
		.stat     (div_st)
	);

	assign pcm_load = (state_q == ST_OUT) && (!pcm_valid_q || !pcm_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			phase_q     <= '0;
			step_q      <= '0;
			vol_q       <= '0;
			idx_q       <= '0;
			total_q     <= '0;
			rl_q        <= '0;
			pcm_valid_q <= 1'b0;
		end else begin
			if (start_ok) begin
				step_q   <= tone.phase_step;
				vol_q    <= tone.volume;
				total_q  <= n_sat;
				rl_q     <= rl_new;
				phase_q  <= '0;
				idx_q    <= '0;
				active_q <= 1'b1;
			end else if (tick_go) begin
				phase_q <= phase_q + PHASE_W'(step_q);
				idx_q   <= idx_q + 1'b1;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end

			if (pcm_load) begin
				pcm_valid_q <= 1'b1;
			end else if (!pcm_stall) begin
				pcm_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (tick_go) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= env_s1 ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (pcm_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			env_s1    <= env;
			factor_s1 <= factor;
			last_s1   <= is_last;
		end
		if (state_q == ST_ROM) begin
			prod_s2 <= 32'(raw_mag) * 32'(vol_q);
			neg_s2  <= raw_neg;
		end
		if (state_q == ST_MUL) begin
			mag_q <= vmag;
			neg_q <= neg_s2;
		end else if ((state_q == ST_DIV) && div_st.done) begin
			mag_q <= div_quo;
		end
		if (pcm_load) begin
			pcm_q.sample <= neg_q ? SMP_W'(-mag_q) : mag_q;
			pcm_q.last   <= last_s1;
		end
	end

	assign pcm_valid = pcm_valid_q;
	assign pcm       = pcm_q;

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q < total_q))
		else $error("sample index ran past tone length");

	a_pcm_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pcm_valid_q) |-> $past(state_q == ST_OUT))
		else $error("sample presented without passing the output state");

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for sine_tone_generator_with_ramp: directed and random tone requests
// against a scoreboard that predicts every PCM sample and its last flag.
// Depends on stg_pkg and the sine_tone_generator_with_ramp RTL.

module tb;
	import stg_pkg::*;

	class tone_scoreboard;
		logic [15:0] sine_tab [1 << DEF_SINE_INDEX_BITS];
		logic [31:0] phase;
		logic [30:0] step;
		logic [15:0] vol;
		int unsigned idx;
		int unsigned total;
		int unsigned ramp;
		bit          running;
		pcm_rsp_t    sample_q [$];
		int unsigned mismatches;

		function new();
			int unsigned quarter;
			int unsigned q;
			int unsigned r;
			longint unsigned m;
			quarter = 1 << (DEF_SINE_INDEX_BITS - 2);
			for (int i = 0; i < (1 << DEF_SINE_INDEX_BITS); i++) begin
				q = (i >> (DEF_SINE_INDEX_BITS - 2)) & 3;
				r = i & (quarter - 1);
				m = q[0] ? quarter_wave(quarter - r) : quarter_wave(r);
				sine_tab[i] = q[1] ? 16'(65536 - m) : 16'(m);
			end
			phase = '0;
			step = '0;
			vol = '0;
			idx = 0;
			total = 0;
			ramp = 0;
			running = 1'b0;
			mismatches = 0;
		endfunction

		// Q2.30 Taylor series of sin over a quarter wave, scaled to 32767
		function longint unsigned quarter_wave(int unsigned k);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned acc;
			longint unsigned r;
			x = (HALF_PI_Q30 * k) >> (DEF_SINE_INDEX_BITS - 2);
			x2 = (x * x) >> 30;
			term = x;
			acc = x;
			for (int n = 1; n <= 10; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			r = (acc * 32767 + (64'd1 << 29)) >> 30;
			if (r > 32767) begin
				r = 32767;
			end
			return r;
		endfunction

		// returns 1 when the request loads a tone or yields a sample
		function bit note_request(tone_req_t r);
			int unsigned n;
			logic [15:0] raw;
			bit          neg;
			int unsigned mag;
			int unsigned prod;
			int unsigned vmag;
			pcm_rsp_t    e;
			if (r.op == OP_START) begin
				if (r.phase_step == '0 || r.length_ms == '0) begin
					return 1'b0;
				end
				n = DEF_SAMPLES_PER_MS * r.length_ms;
				if (n > 65535) begin
					n = 65535;
				end
				ramp = (n / 4 > DEF_RAMP_MAX) ? DEF_RAMP_MAX : n / 4;
				total = n;
				step = r.phase_step;
				vol = r.volume;
				phase = '0;
				idx = 0;
				running = 1'b1;
				return 1'b1;
			end
			if (!running) begin
				return 1'b0;
			end
			raw = sine_tab[phase >> (32 - DEF_SINE_INDEX_BITS)];
			neg = raw[15];
			mag = neg ? 65536 - raw : raw;
			prod = mag * vol;
			vmag = neg ? (prod + 65535) >> 16 : prod >> 16;
			if (vmag == 0) begin
				neg = 1'b0;
			end
			if (ramp != 0) begin
				if (idx < ramp) begin
					vmag = (vmag * idx) / ramp;
				end else if (idx > total - ramp) begin
					vmag = (vmag * (total - idx)) / ramp;
				end
			end
			e.sample = neg ? 16'(65536 - vmag) : 16'(vmag);
			e.last = (idx + 1 >= total);
			sample_q.push_back(e);
			phase = phase + {1'b0, step};
			idx = (idx + 1) & 16'hFFFF;
			if (e.last) begin
				running = 1'b0;
			end
			return 1'b1;
		endfunction

		function int unsigned pending();
			return sample_q.size();
		endfunction

		task report(string what);
			mismatches++;
			$display("ERROR: %s", what);
		endtask

		task check_sample(pcm_rsp_t got);
			pcm_rsp_t e;
			if (sample_q.size() == 0) begin
				report($sformatf("unexpected sample %0d last %0b", got.sample, got.last));
				return;
			end
			e = sample_q.pop_front();
			if (got.sample !== e.sample) begin
				report($sformatf("sample: got %0d expected %0d", got.sample, e.sample));
			end
			if (got.last !== e.last) begin
				report($sformatf("last: got %0b expected %0b", got.last, e.last));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      tone_valid;
	logic      tone_stall;
	tone_req_t tone;
	logic      pcm_valid;
	logic      pcm_stall;
	pcm_rsp_t  pcm;

	bit          calm;
	int unsigned accepted;
	int unsigned tones;

	tone_scoreboard sb = new();

	sine_tone_generator_with_ramp u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.tone_valid (tone_valid),
		.tone_stall (tone_stall),
		.tone       (tone),
		.pcm_valid  (pcm_valid),
		.pcm_stall  (pcm_stall),
		.pcm        (pcm)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic tone_req_t make_req(logic op, logic [30:0] step, logic [11:0] dur,
			logic [15:0] vol);
		tone_req_t r;
		r.op = op;
		r.phase_step = step;
		r.length_ms = dur;
		r.volume = vol;
		return r;
	endfunction

	// ticks carry junk in the operand fields
	function automatic tone_req_t tick_req();
		return make_req(OP_TICK, 31'($urandom()), 12'($urandom()), 16'($urandom()));
	endfunction

	function automatic logic [30:0] rand_step();
		int unsigned pick;
		logic [30:0] s;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return 31'h7FFF_FFFF;
		end
		if (pick < 4) begin
			return 31'($urandom_range(1, 1 << 22));
		end
		s = 31'($urandom());
		return (s == '0) ? 31'd1 : s;
	endfunction

	function automatic logic [15:0] rand_vol();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			return 16'h0000;
		end
		if (pick == 1) begin
			return 16'hFFFF;
		end
		return 16'($urandom());
	endfunction

	function automatic tone_req_t ignored_req();
		int unsigned pick;
		pick = $urandom_range(0, 2);
		if (pick == 0) begin
			return make_req(OP_START, '0, 12'($urandom()), rand_vol());
		end
		if (pick == 1) begin
			return make_req(OP_START, rand_step(), '0, rand_vol());
		end
		return make_req(OP_START, '0, '0, rand_vol());
	endfunction

	task automatic send_req(input tone_req_t r);
		while (!calm && $urandom_range(0, 99) < 18) begin
			tone_valid <= 1'b0;
			@(posedge clk);
		end
		tone_valid <= 1'b1;
		tone <= r;
		@(posedge clk);
		while (tone_stall) begin
			@(posedge clk);
		end
		if (sb.note_request(r)) begin
			accepted++;
		end
		calm = (accepted >= 300 && accepted < 500);
	endtask

	// hold off new requests until every predicted sample has come back
	task automatic drain();
		tone_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		pcm_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pcm_valid && !pcm_stall) begin
				sb.check_sample(pcm);
			end
			pcm_stall <= !calm && ($urandom_range(0, 99) < 18);
		end
	end

	initial begin
		int unsigned kind;
		int unsigned pick;
		int unsigned dur;
		int unsigned ticks;
		tone_req_t   r;
		tone_valid = 1'b0;
		tone = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		accepted = 0;
		tones = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, rejected starts, full shortest tone at max step and volume
		send_req(tick_req());
		send_req(make_req(OP_START, '0, 12'd5, 16'hFFFF));
		send_req(make_req(OP_START, 31'd1, '0, 16'hFFFF));
		send_req(make_req(OP_START, 31'h7FFF_FFFF, 12'd1, 16'hFFFF));
		repeat (17) send_req(tick_req());
		// longest tone, zero volume, quarter-wave step; rejected zero-step start mid-tone; restart
		send_req(make_req(OP_START, 31'h4000_0000, 12'hFFF, 16'h0000));
		send_req(tick_req());
		send_req(make_req(OP_START, '0, 12'd3, 16'h1234));
		send_req(tick_req());
		send_req(make_req(OP_START, 31'h1000_0000, 12'd2, 16'h8000));
		repeat (3) send_req(tick_req());
		drain();

		while (accepted < 1050) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				tones++;
				if (tones == 12) begin
					drain();
				end
				pick = $urandom_range(0, 9);
				if (tones == 4) begin
					dur = 20 + $urandom_range(0, 3);
				end else if (pick < 6) begin
					dur = 1;
				end else if (pick < 9) begin
					dur = $urandom_range(2, 6);
				end else begin
					dur = $urandom_range(7, 12);
				end
				ticks = dur * DEF_SAMPLES_PER_MS;
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					ticks = $urandom_range(1, ticks - 1);
				end else if (pick < 4) begin
					ticks += $urandom_range(1, 3);
				end
				send_req(make_req(OP_START, rand_step(), 12'(dur), rand_vol()));
				repeat (ticks) begin
					if ($urandom_range(0, 99) < 3) begin
						send_req(ignored_req());
					end
					send_req(tick_req());
				end
			end else if (kind < 80) begin
				send_req(ignored_req());
			end else if (kind < 88) begin
				send_req(make_req(OP_START, rand_step(), 12'($urandom_range(13, 4095)),
					rand_vol()));
				repeat ($urandom_range(5, 40)) send_req(tick_req());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					r = tick_req();
					r.op = $urandom_range(0, 1) ? OP_START : OP_TICK;
					send_req(r);
				end
			end
		end

		tone_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
